### hdl/zone_grant_ack_table_assert.svh
// Assertion macros shared by the zone grant/acknowledge table checkers.
`ifndef ZONE_GRANT_ACK_TABLE_ASSERT_SVH
`define ZONE_GRANT_ACK_TABLE_ASSERT_SVH

// Clocked assertion, suspended while reset is high.
`define ZGAT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("zone_grant_ack_table assertion failed");

// Clocked assertion that also holds across reset.
`define ZGAT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("zone_grant_ack_table assertion failed");

`endif

### hdl/zgat_pkg.sv
// Types and codes for the zone grant/acknowledge table.
package zgat_pkg;

   localparam int ZONE_W = 64;

   // request modes
   localparam logic [1:0] MODE_GRANT  = 2'd0;
   localparam logic [1:0] MODE_REVOKE = 2'd1;
   localparam logic [1:0] MODE_ACK    = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;

   // zone states reported in a result word
   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_GRANTED = 2'd1;
   localparam logic [1:0] ST_ACKED   = 2'd2;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ZONE_W-1:0] zone;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] zone_state;
      logic       can_receive;
      logic       full_res;
   } rsp_type;

endpackage

### hdl/zgat_table.sv
// Slot storage with parallel zone match, lowest-free-slot pick and update.
module zgat_table #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  zgat_pkg::req_type req,
   output zgat_pkg::rsp_type rsp
);

   logic [zgat_pkg::ZONE_W-1:0] slot_zone_ff [SLOTS];
   logic [SLOTS-1:0] slot_used_ff;
   logic [SLOTS-1:0] slot_used_in;
   logic [SLOTS-1:0] slot_acked_ff;
   logic [SLOTS-1:0] slot_acked_in;

   logic [SLOTS-1:0] match;
   logic [SLOTS-1:0] free_vec;
   logic [SLOTS-1:0] free_oh;
   logic [SLOTS-1:0] ins_vec;
   logic [SLOTS-1:0] clr_vec;
   logic [SLOTS-1:0] ack_vec;
   logic             zone_nz;
   logic             hit;
   logic             hit_acked;
   logic             have_free;
   logic             ok;
   logic             full;
   logic [1:0]       state;

   // parallel compare against every used slot; zones are unique in the table
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = slot_used_ff[i] && (slot_zone_ff[i] == req.zone);
      end
   end

   assign zone_nz   = |req.zone;
   assign hit       = zone_nz && |match;
   assign hit_acked = |(match & slot_acked_ff);

   // lowest free slot as a one-hot vector
   assign free_vec  = ~slot_used_ff;
   assign free_oh   = free_vec & (~free_vec + SLOTS'(1));
   assign have_free = |free_vec;

   // operation decode
   always_comb begin
      ok      = 1'b0;
      full    = 1'b0;
      state   = zgat_pkg::ST_NONE;
      ins_vec = '0;
      clr_vec = '0;
      ack_vec = '0;
      if (zone_nz) begin
         unique case (req.mode)
            zgat_pkg::MODE_GRANT: begin
               if (hit) begin
                  state = hit_acked ? zgat_pkg::ST_ACKED : zgat_pkg::ST_GRANTED;
               end else if (have_free) begin
                  ins_vec = free_oh;
                  ok      = 1'b1;
                  state   = zgat_pkg::ST_GRANTED;
               end else begin
                  full = 1'b1;
               end
            end
            zgat_pkg::MODE_REVOKE: begin
               if (hit) begin
                  clr_vec = match;
                  ok      = 1'b1;
               end
            end
            zgat_pkg::MODE_ACK: begin
               if (hit) begin
                  ack_vec = match;
                  ok      = 1'b1;
                  state   = zgat_pkg::ST_ACKED;
               end
            end
            zgat_pkg::MODE_QUERY: begin
               if (hit) begin
                  ok    = 1'b1;
                  state = hit_acked ? zgat_pkg::ST_ACKED : zgat_pkg::ST_GRANTED;
               end
            end
            default: begin
               ok = 1'b0;
            end
         endcase
      end
   end

   assign rsp.ok          = ok;
   assign rsp.zone_state  = state;
   assign rsp.can_receive = !zone_nz || (state == zgat_pkg::ST_ACKED);
   assign rsp.full_res    = full;

   // next slot flags
   assign slot_used_in  = (slot_used_ff | ins_vec) & ~clr_vec;
   assign slot_acked_in = (slot_acked_ff & ~clr_vec & ~ins_vec) | ack_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff  <= '0;
         slot_acked_ff <= '0;
      end else if (commit) begin
         slot_used_ff  <= slot_used_in;
         slot_acked_ff <= slot_acked_in;
      end
   end

   // zone storage, written into the chosen free slot
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (commit && ins_vec[i]) begin
            slot_zone_ff[i] <= req.zone;
         end
      end
   end

endmodule

### hdl/zone_grant_ack_table.sv
// Top level of the zone grant/acknowledge table.
//
// Request channel (req_valid, req_stall, req_data) carries one word: a mode
// (grant, revoke, acknowledge, query) and a 64-bit zone. Every request gives
// exactly one result word on the response channel (rsp_valid, rsp_stall,
// rsp_data): ok, zone_state, can_receive and full_res.
// A word is taken at a clock edge where valid is high and stall is low.
// A taken request is held in the input register until the result register
// is free, and its result is then loaded into the result register.
// Throughput: one request per cycle while rsp_stall does not hold the result
// register. The request is held in an input register, looked up against all
// SLOTS entries in parallel and the table updated at the same edge that loads
// the result register, so the next request always sees the updated table.
// Reset (synchronous, active high) empties the table and both registers;
// req_stall is low in the cycle after reset.
// When rsp_stall holds the result register, the input register fills and
// req_stall rises in the same cycle that it cannot drain.
module zone_grant_ack_table #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  zgat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output zgat_pkg::rsp_type rsp_data
);

   logic              s1_valid_ff;
   logic              s1_valid_in;
   zgat_pkg::req_type s1_word_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   zgat_pkg::rsp_type rsp_word_ff;
   zgat_pkg::rsp_type lookup_rsp;
   logic              out_free;
   logic              advance;
   logic              req_take;

   // handshake control
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = s1_valid_ff && out_free;
   assign req_stall    = s1_valid_ff && !out_free;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_data;
      end
   end

   // table lookup and update
   zgat_table #(
      .SLOTS (SLOTS)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .req    (s1_word_ff),
      .rsp    (lookup_rsp)
   );

   // result word register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= lookup_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

### hdl/zgat_checker.sv
// Port-level checker for the zone grant/acknowledge table, bound to the top.
`include "zone_grant_ack_table_assert.svh"

module zgat_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input zgat_pkg::rsp_type rsp_data
);

   logic full_clean;

   // a failed grant carries no ok flag and no zone state
   assign full_clean = !rsp_data.ok && (rsp_data.zone_state == zgat_pkg::ST_NONE);

   // a held result word stays offered
   `ZGAT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // a held result word does not change
   `ZGAT_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data))

   // with the result register empty the block never pushes back
   `ZGAT_ASSERT(a_no_stall_empty, clock, reset, !rsp_valid |-> !req_stall)

   // the pipeline is empty right after reset
   `ZGAT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !req_stall && !rsp_valid)

   // a full table report is a failed grant with no state
   `ZGAT_ASSERT(a_full_fail, clock, reset, rsp_valid && rsp_data.full_res |-> full_clean)

endmodule

bind zone_grant_ack_table zgat_checker u_zgat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
